FILE: rtl/core/csbe_pkg.sv
// Shared types, widths and register indexes for the cell scan balance block.
`default_nettype none
package csbe_pkg;

  // Fixed field widths of the request and result items
  localparam int MV_W     = 16;
  localparam int TEMP_W   = 16;
  localparam int MOD_W    = 3;
  localparam int CELL_W   = 4;
  localparam int VEC_W    = 12;
  localparam int SUM_W    = 23;

  // Default pack geometry
  localparam int NUM_MODULES_DEF      = 8;
  localparam int CELLS_PER_MODULE_DEF = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CELL          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CELL          = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_TEMP    = 2'd3;

  localparam logic [MV_W-1:0]   MIN_CELL_RST = '0;
  localparam logic [MV_W-1:0]   MAX_CELL_RST = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX      = '1;

  typedef struct packed {
    logic        [MV_W-1:0]   cell_mv;
    logic signed [TEMP_W-1:0] cell_temp;
    logic                     last_in_module;
    logic                     last_in_pack;
  } in_item_t;

  typedef struct packed {
    logic [MOD_W-1:0]  module_index;
    logic [VEC_W-1:0]  balance_vector;
    logic              threshold_ok;
    logic              pack_done;
    logic              balancing_done;
    logic [MV_W-1:0]   lowest_mv;
    logic [MOD_W-1:0]  lowest_module;
    logic [CELL_W-1:0] lowest_cell;
    logic [MV_W-1:0]   highest_mv;
    logic [MOD_W-1:0]  highest_module;
    logic [CELL_W-1:0] highest_cell;
    logic [SUM_W-1:0]  pack_sum_mv;
  } out_item_t;

  typedef struct packed {
    logic        [MV_W-1:0]   balance_threshold_mv;
    logic        [MV_W-1:0]   min_cell_mv;
    logic        [MV_W-1:0]   max_cell_mv;
    logic signed [TEMP_W-1:0] discharge_temp_limit;
  } cfg_t;

  // Handshake between the scan unit and its neighbors
  typedef struct packed {
    logic take;  // staged request is consumed this cycle
    logic emit;  // a result is loaded into the output register
  } scan_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/csbe_in_stage.sv
// Input register stage holding one accepted cell request.
`default_nettype none
module csbe_in_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire csbe_pkg::in_item_t in_item,
  input  wire logic               take,
  output logic                    stg_valid,
  output csbe_pkg::in_item_t      stg_item
);

  logic               valid_r, valid_nxt;
  csbe_pkg::in_item_t item_r;
  logic               accept;

  assign in_stall  = valid_r && !take;
  assign accept    = in_valid && !in_stall;
  assign stg_valid = valid_r;
  assign stg_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // hold payload while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/csbe_scan.sv
// Scan state: discharge vector, extremes, sum and module/cell counters.
`default_nettype none
module csbe_scan #(
  parameter int NUM_MODULES      = csbe_pkg::NUM_MODULES_DEF,
  parameter int CELLS_PER_MODULE = csbe_pkg::CELLS_PER_MODULE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                stg_valid,
  input  wire csbe_pkg::in_item_t  stg_item,
  input  wire csbe_pkg::cfg_t      cfg,
  input  wire logic                out_ready,
  output csbe_pkg::scan_ctl_t      ctl,
  output csbe_pkg::out_item_t      res
);

  localparam int MODC_W  = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
  localparam int CELLC_W = (CELLS_PER_MODULE > 1) ? $clog2(CELLS_PER_MODULE) : 1;
  localparam logic [MODC_W-1:0]  MOD_LAST  = MODC_W'(NUM_MODULES - 1);
  localparam logic [CELLC_W-1:0] CELL_LAST = CELLC_W'(CELLS_PER_MODULE - 1);

  logic [MODC_W-1:0]              mod_cnt_r, mod_cnt_nxt;
  logic [CELLC_W-1:0]             cell_cnt_r, cell_cnt_nxt;
  logic [csbe_pkg::VEC_W-1:0]     vec_r, vec_nxt, vec_upd;
  logic                           first_r, first_nxt;
  logic                           any_r, any_nxt, any_upd;
  logic [csbe_pkg::SUM_W-1:0]     sum_r, sum_nxt, sum_upd;
  logic [csbe_pkg::SUM_W:0]       sum_wide;
  logic [csbe_pkg::MV_W-1:0]      low_val_r, low_val_nxt, high_val_r, high_val_nxt;
  logic [csbe_pkg::MOD_W-1:0]     low_mod_r, low_mod_nxt, high_mod_r, high_mod_nxt;
  logic [csbe_pkg::CELL_W-1:0]    low_cell_r, low_cell_nxt, high_cell_r, high_cell_nxt;
  logic [csbe_pkg::MOD_W-1:0]     mod_loc;
  logic [csbe_pkg::CELL_W-1:0]    cell_loc;
  logic                           above, cool, closes, ok, fire;

  assign mod_loc  = csbe_pkg::MOD_W'(mod_cnt_r);
  assign cell_loc = csbe_pkg::CELL_W'(cell_cnt_r);
  assign above    = stg_item.cell_mv > cfg.balance_threshold_mv;
  assign cool     = cfg.discharge_temp_limit > stg_item.cell_temp;
  assign closes   = stg_item.last_in_module || stg_item.last_in_pack;
  assign ok       = (cfg.balance_threshold_mv >= cfg.min_cell_mv) &&
                    (cfg.balance_threshold_mv <= cfg.max_cell_mv);

  // a request that closes a module needs room in the output register
  assign fire     = stg_valid && (out_ready || !closes);
  assign ctl.take = fire;
  assign ctl.emit = fire && closes;

  always_comb begin
    vec_upd = vec_r;
    for (int j = 0; j < csbe_pkg::VEC_W; j++) begin
      if (above && cool && (cell_loc == csbe_pkg::CELL_W'(j))) begin
        vec_upd[j] = 1'b1;
      end
    end
  end

  assign any_upd  = any_r || above;
  assign sum_wide = {1'b0, sum_r} + (csbe_pkg::SUM_W + 1)'(stg_item.cell_mv);
  assign sum_upd  = sum_wide[csbe_pkg::SUM_W] ? csbe_pkg::SUM_MAX
                                              : sum_wide[csbe_pkg::SUM_W-1:0];

  // extremes: first cell seeds both, then only strict improvements replace
  always_comb begin
    low_val_nxt   = low_val_r;
    low_mod_nxt   = low_mod_r;
    low_cell_nxt  = low_cell_r;
    high_val_nxt  = high_val_r;
    high_mod_nxt  = high_mod_r;
    high_cell_nxt = high_cell_r;
    priority if (first_r) begin
      low_val_nxt   = stg_item.cell_mv;
      low_mod_nxt   = mod_loc;
      low_cell_nxt  = cell_loc;
      high_val_nxt  = stg_item.cell_mv;
      high_mod_nxt  = mod_loc;
      high_cell_nxt = cell_loc;
    end else if (stg_item.cell_mv > high_val_r) begin
      high_val_nxt  = stg_item.cell_mv;
      high_mod_nxt  = mod_loc;
      high_cell_nxt = cell_loc;
    end else if (stg_item.cell_mv < low_val_r) begin
      low_val_nxt   = stg_item.cell_mv;
      low_mod_nxt   = mod_loc;
      low_cell_nxt  = cell_loc;
    end else begin
      // equal to an extreme or between them: hold both
    end
  end

  always_comb begin
    res = '0;
    res.module_index   = mod_loc;
    res.balance_vector = ok ? vec_upd : '0;
    res.threshold_ok   = ok;
    if (stg_item.last_in_pack) begin
      res.pack_done      = 1'b1;
      res.balancing_done = ok && !any_upd;
      res.lowest_mv      = low_val_nxt;
      res.lowest_module  = low_mod_nxt;
      res.lowest_cell    = low_cell_nxt;
      res.highest_mv     = high_val_nxt;
      res.highest_module = high_mod_nxt;
      res.highest_cell   = high_cell_nxt;
      res.pack_sum_mv    = sum_upd;
    end
  end

  always_comb begin
    mod_cnt_nxt  = mod_cnt_r;
    cell_cnt_nxt = cell_cnt_r;
    vec_nxt      = vec_upd;
    first_nxt    = 1'b0;
    any_nxt      = any_upd;
    sum_nxt      = sum_upd;
    priority if (stg_item.last_in_pack) begin
      mod_cnt_nxt  = '0;
      cell_cnt_nxt = '0;
      vec_nxt      = '0;
      first_nxt    = 1'b1;
      any_nxt      = 1'b0;
      sum_nxt      = '0;
    end else if (stg_item.last_in_module) begin
      cell_cnt_nxt = '0;
      vec_nxt      = '0;
      if (mod_cnt_r < MOD_LAST) begin
        mod_cnt_nxt = mod_cnt_r + 1'b1;
      end
    end else begin
      if (cell_cnt_r < CELL_LAST) begin
        cell_cnt_nxt = cell_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_cnt_r  <= '0;
      cell_cnt_r <= '0;
      vec_r      <= '0;
      first_r    <= 1'b1;
      any_r      <= 1'b0;
      sum_r      <= '0;
    end else if (fire) begin
      mod_cnt_r  <= mod_cnt_nxt;
      cell_cnt_r <= cell_cnt_nxt;
      vec_r      <= vec_nxt;
      first_r    <= first_nxt;
      any_r      <= any_nxt;
      sum_r      <= sum_nxt;
    end
  end

  // extremes are seeded by the first cell, so they need no reset
  always_ff @(posedge clk) begin
    if (fire) begin
      low_val_r   <= low_val_nxt;
      low_mod_r   <= low_mod_nxt;
      low_cell_r  <= low_cell_nxt;
      high_val_r  <= high_val_nxt;
      high_mod_r  <= high_mod_nxt;
      high_cell_r <= high_cell_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/csbe_out_stage.sv
// Output register holding one result until the consumer takes it.
`default_nettype none
module csbe_out_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                emit,
  input  wire csbe_pkg::out_item_t res,
  output logic                     out_ready,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output csbe_pkg::out_item_t      out_item
);

  logic                valid_r, valid_nxt;
  csbe_pkg::out_item_t item_r;

  assign out_ready = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (emit) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      item_r <= res;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/cell_scan_balance_extremes.sv
// Top level of the cell scan balance block: config registers and pipeline.
`default_nettype none
// Takes one cell sample per request (voltage, temperature, module and pack
// end marks) in module order and cell order, and accepts a new request every
// clock cycle unless stalled. A request that closes a module returns one
// result through the input and output registers: the module's discharge
// vector and threshold_ok, and on the pack's last cell also the lowest and
// highest voltage with their module and cell, the saturating voltage sum
// and balancing_done. Requests that do not close a module return nothing.
// The figure of one request per cycle is set by the scan unit, which updates
// counters, vector, extremes and sum; the output register keeps that rate
// while a result waits and stalls the stream only when full and stalled downstream.
module cell_scan_balance_extremes #(
  parameter int NUM_MODULES      = csbe_pkg::NUM_MODULES_DEF,
  parameter int CELLS_PER_MODULE = csbe_pkg::CELLS_PER_MODULE_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire csbe_pkg::in_item_t                  in_item,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output csbe_pkg::out_item_t                      out_item,
  input  wire logic                                cfg_we,
  input  wire logic [csbe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [csbe_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  csbe_pkg::cfg_t      cfg_r, cfg_nxt;
  csbe_pkg::in_item_t  stg_item;
  csbe_pkg::out_item_t res;
  csbe_pkg::scan_ctl_t ctl;
  logic                stg_valid;
  logic                out_ready;

  // Configuration writes land directly; the user must make them only while the block idles (not enforced).
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        csbe_pkg::CFG_BALANCE_THRESHOLD: cfg_nxt.balance_threshold_mv = cfg_wdata;
        csbe_pkg::CFG_MIN_CELL:          cfg_nxt.min_cell_mv          = cfg_wdata;
        csbe_pkg::CFG_MAX_CELL:          cfg_nxt.max_cell_mv          = cfg_wdata;
        csbe_pkg::CFG_DISCHARGE_TEMP:    cfg_nxt.discharge_temp_limit = $signed(cfg_wdata);
        default:                         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.balance_threshold_mv <= '0;
      cfg_r.min_cell_mv          <= csbe_pkg::MIN_CELL_RST;
      cfg_r.max_cell_mv          <= csbe_pkg::MAX_CELL_RST;
      cfg_r.discharge_temp_limit <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Hold the accepted request until the scan unit takes it.
  csbe_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .take      (ctl.take),
    .stg_valid (stg_valid),
    .stg_item  (stg_item)
  );

  // Advance the scan state; a module-closing request waits for output room.
  csbe_scan #(
    .NUM_MODULES      (NUM_MODULES),
    .CELLS_PER_MODULE (CELLS_PER_MODULE)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .stg_valid (stg_valid),
    .stg_item  (stg_item),
    .cfg       (cfg_r),
    .out_ready (out_ready),
    .ctl       (ctl),
    .res       (res)
  );

  // Register the result; the consumer's stall blocks the scan only for a module-closing request while it is full.
  csbe_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (ctl.emit),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

FILE: rtl/core/csbe_checker.sv
// Port-level assertions for the cell scan balance block, bound to its top.
`default_nettype none
module csbe_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire csbe_pkg::out_item_t out_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_vec_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.threshold_ok |->
      out_item.balance_vector == '0 && !out_item.balancing_done)
    else $error("vector or balancing_done set with bad threshold");

  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.pack_done |->
      out_item.pack_sum_mv == '0 && out_item.lowest_mv == '0 &&
      out_item.highest_mv == '0 && !out_item.balancing_done)
    else $error("summary fields set on a module result");

  a_extremes_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.pack_done |-> out_item.lowest_mv <= out_item.highest_mv)
    else $error("lowest voltage above highest");

  a_done_no_vector: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.balancing_done |-> out_item.balance_vector == '0)
    else $error("balancing_done with discharge bits set");

endmodule

bind cell_scan_balance_extremes csbe_checker u_csbe_checker (.*);
`default_nettype wire
